>>> sv/kwf_pkg.sv
// Package with constants, keyword table and command types for the keyword frequency counter.
package kwf_pkg;

	localparam int KEYWORD_COUNT = 54;
	localparam int KW_IDX_BITS   = $clog2(KEYWORD_COUNT);
	localparam int WINDOW_BYTES  = 11;
	localparam int WIN_IDX_BITS  = $clog2(WINDOW_BYTES);
	localparam int KEY_MAX_LEN   = 10;
	localparam int SEEN_BITS     = 4;
	localparam int COUNTER_BITS  = 17;
	localparam int SHARE_BITS    = 14;
	localparam int PROD_BITS     = COUNTER_BITS + SHARE_BITS;
	localparam int NUM_BITS      = PROD_BITS + 1;
	localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

	localparam logic [SHARE_BITS-1:0] SHARE_SCALE = 14'd10000;
	localparam logic [SEEN_BITS-1:0]  SEEN_MAX    = '1;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;

	// Keyword text, right aligned: the last character sits in the low byte.
	localparam logic [8*KEY_MAX_LEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
		"make", "address", "all", "3d", "our", "over", "remove", "internet",
		"order", "mail", "receive", "will", "people", "report", "addresses",
		"free", "business", "email", "you", "credit", "your", "font", "000",
		"money", "hp", "hpl", "george", "650", "lab", "labs", "telnet", "857",
		"data", "415", "85", "technology", "1999", "parts", "pm", "direct",
		"cs", "meeting", "original", "project", "re", "edu", "table",
		"conference", ";", "(", "[", "!", "$", "#"
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                   byte_go;
		logic                   byte_last;
		logic [KW_IDX_BITS-1:0] kw_idx;
		logic                   mul_go;
		logic                   div_load;
		logic                   div_step;
		logic                   emit_load;
		logic                   clear;
	} kwf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic out_free;
	} kwf_sts_t;

	function automatic int unsigned kw_len(input logic [8*KEY_MAX_LEN-1:0] t);
		int unsigned n;
		n = 0;
		for (int j = 0; j < KEY_MAX_LEN; j++) begin
			if (t[8*j +: 8] != 8'h00) n++;
		end
		return n;
	endfunction

	function automatic logic is_edge(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_NEWLINE);
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return is_edge(b) || (b == CH_TAB);
	endfunction

endpackage

>>> sv/keyword_word_frequency_counter.sv
// Top level of the keyword whole-word frequency counter.
// Throughput: one text byte per cycle while a message streams in.
// After the final byte, each of the 54 shares takes a read, a scale multiply, a load,
// a restoring divider and an emit, plus output stalls; a drain state comes before
// the sequence and a clear state after it, before the next message is taken.
// Reset is asynchronous, active low, and clears all counts, the window and the hit flags.
module keyword_word_frequency_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_message,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kwf_pkg::KW_IDX_BITS-1:0] keyword_index,
	output logic [kwf_pkg::SHARE_BITS-1:0]  share_hundredths,
	output logic                            last_share
);
	import kwf_pkg::*;

	kwf_cmd_t cmd;
	kwf_sts_t sts;

	kwf_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.end_of_message (end_of_message),
		.sts            (sts),
		.cmd            (cmd)
	);

	kwf_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.text_byte        (text_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.keyword_index    (keyword_index),
		.share_hundredths (share_hundredths),
		.last_share       (last_share)
	);

endmodule

>>> sv/kwf_ctrl.sv
// Controller state machine: byte intake, per-keyword share sequence and clearing.
module kwf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              end_of_message,
	input  kwf_pkg::kwf_sts_t sts,
	output kwf_pkg::kwf_cmd_t cmd
);
	import kwf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DRAIN, ST_READ, ST_MUL, ST_LOAD, ST_DIV, ST_EMIT, ST_CLEAR
	} state_t;

	state_t                 state_q;
	logic [KW_IDX_BITS-1:0] kw_q;
	logic                   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Command decode from the current state.
	always_comb begin
		cmd           = '0;
		cmd.byte_go   = accept;
		cmd.byte_last = accept && end_of_message;
		cmd.kw_idx    = kw_q;
		cmd.mul_go    = (state_q == ST_MUL);
		cmd.div_load  = (state_q == ST_LOAD);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.emit_load = (state_q == ST_EMIT) && sts.out_free;
		cmd.clear     = (state_q == ST_CLEAR);
	end

	// State and keyword counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kw_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					kw_q <= '0;
					if (accept && end_of_message) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_READ;
				ST_READ:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_LOAD;
				ST_LOAD:  state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (kw_q == KW_IDX_BITS'(KEYWORD_COUNT - 1)) begin
							state_q <= ST_CLEAR;
						end else begin
							kw_q    <= kw_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_CLEAR: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/kwf_dp.sv
// Datapath: byte window, word and hit counters, hit memory, divider and output register.
module kwf_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kwf_pkg::kwf_cmd_t                    cmd,
	output kwf_pkg::kwf_sts_t                    sts,
	input  logic [7:0]                           text_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [kwf_pkg::KW_IDX_BITS-1:0]      keyword_index,
	output logic [kwf_pkg::SHARE_BITS-1:0]       share_hundredths,
	output logic                                 last_share
);
	import kwf_pkg::*;

	logic [7:0]              win_q [WINDOW_BYTES];
	logic [SEEN_BITS-1:0]    seen_q;
	logic [COUNTER_BITS-1:0] word_total_q;

	logic [KEYWORD_COUNT-1:0] hit_vec;
	logic                     hit_any;
	logic [KW_IDX_BITS-1:0]   hit_idx;
	logic                     hit_s1;
	logic [KW_IDX_BITS-1:0]   idx_s1;

	logic [COUNTER_BITS-1:0]  hits_mem [KEYWORD_COUNT];
	logic [KEYWORD_COUNT-1:0] hits_vld_q;
	logic [COUNTER_BITS-1:0]  hits_rd_q;
	logic                     hits_rd_vld_q;
	logic [COUNTER_BITS-1:0]  hits_cur;
	logic [COUNTER_BITS-1:0]  hits_inc;
	logic [KW_IDX_BITS-1:0]   rd_addr;

	logic [PROD_BITS-1:0]     prod_w;
	logic [PROD_BITS-1:0]     prod_q;
	logic [NUM_BITS-1:0]      num_q;
	logic [COUNTER_BITS-1:0]  rem_q;
	logic [DIV_CNT_BITS-1:0]  div_cnt_q;
	logic [COUNTER_BITS:0]    rem_shift;
	logic                     q_bit;
	logic [SHARE_BITS-1:0]    share_w;

	logic                     out_valid_q;
	logic [KW_IDX_BITS-1:0]   keyword_index_q;
	logic [SHARE_BITS-1:0]    share_q;
	logic                     last_q;

	// Keyword matches that end at the newest window byte, closed by the incoming byte.
	always_comb begin
		int unsigned len;
		logic        m;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			len = kw_len(KW_TEXT[k]);
			m   = (len != 0) && (len < WINDOW_BYTES) && (seen_q >= len);
			for (int j = 0; j < KEY_MAX_LEN; j++) begin
				if (j < len && win_q[j] != KW_TEXT[k][8*j +: 8]) m = 1'b0;
			end
			if (m && !(seen_q == len || is_edge(win_q[WIN_IDX_BITS'(len)]))) m = 1'b0;
			hit_vec[k] = m && cmd.byte_go && is_edge(text_byte);
		end
	end

	// Encode the single hit.
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				hit_any = 1'b1;
				hit_idx = KW_IDX_BITS'(k);
			end
		end
	end

	// Byte window, byte count and word count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_BYTES; i++) win_q[i] <= '0;
			seen_q       <= '0;
			word_total_q <= '0;
		end else begin
			if (cmd.byte_go) begin
				if (!is_blank(text_byte) && (seen_q == '0 || is_blank(win_q[0]))
				    && word_total_q != '1) begin
					word_total_q <= word_total_q + 1'b1;
				end
				if (cmd.byte_last) begin
					for (int i = 0; i < WINDOW_BYTES; i++) win_q[i] <= '0;
					seen_q <= '0;
				end else begin
					for (int i = WINDOW_BYTES - 1; i > 0; i--) win_q[i] <= win_q[i-1];
					win_q[0] <= text_byte;
					if (seen_q != SEEN_MAX) seen_q <= seen_q + 1'b1;
				end
			end
			if (cmd.clear) word_total_q <= '0;
		end
	end

	// Hit counter read-modify-write: registered read, write-back in the cycle after, with forwarding.
	assign rd_addr  = cmd.byte_go ? hit_idx : cmd.kw_idx;
	assign hits_cur = hits_rd_vld_q ? hits_rd_q : '0;
	assign hits_inc = (hits_cur == '1) ? hits_cur : hits_cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1        <= 1'b0;
			idx_s1        <= '0;
			hits_vld_q    <= '0;
			hits_rd_vld_q <= 1'b0;
		end else begin
			hit_s1 <= hit_any;
			idx_s1 <= hit_idx;
			if (hit_s1 && rd_addr == idx_s1) begin
				hits_rd_vld_q <= 1'b1;
			end else begin
				hits_rd_vld_q <= hits_vld_q[rd_addr];
			end
			if (hit_s1) hits_vld_q[idx_s1] <= 1'b1;
			if (cmd.clear) hits_vld_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1) hits_mem[idx_s1] <= hits_inc;
		if (hit_s1 && rd_addr == idx_s1) begin
			hits_rd_q <= hits_inc;
		end else begin
			hits_rd_q <= hits_mem[rd_addr];
		end
	end

	// Scale, then restoring division one quotient bit per cycle.
	assign prod_w    = hits_cur * SHARE_SCALE;
	assign rem_shift = {rem_q, num_q[NUM_BITS-1]};
	assign q_bit     = (rem_shift >= {1'b0, word_total_q});

	always_ff @(posedge clk) begin
		if (cmd.mul_go) prod_q <= prod_w;
		if (cmd.div_load) begin
			num_q <= NUM_BITS'(prod_q) + NUM_BITS'(word_total_q[COUNTER_BITS-1:1]);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_BITS-2:0], q_bit};
			rem_q <= q_bit ? COUNTER_BITS'(rem_shift - {1'b0, word_total_q})
			               : rem_shift[COUNTER_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	assign sts.div_last = (div_cnt_q == DIV_CNT_BITS'(NUM_BITS - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	// Clamp the quotient; no words gives a share of zero.
	always_comb begin
		if (word_total_q == '0) begin
			share_w = '0;
		end else if (num_q > NUM_BITS'(SHARE_SCALE)) begin
			share_w = SHARE_SCALE;
		end else begin
			share_w = num_q[SHARE_BITS-1:0];
		end
	end

	// Output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			keyword_index_q <= cmd.kw_idx;
			share_q         <= share_w;
			last_q          <= (cmd.kw_idx == KW_IDX_BITS'(KEYWORD_COUNT - 1));
		end
	end

	assign out_valid        = out_valid_q;
	assign keyword_index    = keyword_index_q;
	assign share_hundredths = share_q;
	assign last_share       = last_q;

`ifndef SYNTH
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("more than one keyword hit on one byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !(out_valid_q && out_stall))
		else $error("output beat overwritten while stalled");
	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (share_q <= SHARE_SCALE))
		else $error("share above full scale");
	a_no_hit_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !hit_s1)
		else $error("hit counter write during division");
`endif

endmodule
